/* hw/rtl/ptc_pkg.sv */
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared widths, constants and register indexes of the pressure and
// temperature compensation block.
// ----------------------------------------------------------------------------
package ptc_pkg;

  // Datapath and field widths.
  localparam int DATA_W    = 64;
  localparam int CNT_W     = $clog2(DATA_W + 1);
  localparam int RAW_W     = 20;
  localparam int FINE_W    = 32;
  localparam int OUT_W     = 32;
  localparam int CFG_IDX_W = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_CAL   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_LOW  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_HIGH = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_NINE = 8'd3;

  // Compensation constants.
  localparam logic [RAW_W-1:0]  SKIP_MARK   = 20'h80000;
  localparam logic [DATA_W-1:0] TEMP_OFFSET = 64'd128000;
  localparam logic [RAW_W:0]    PRESS_BASE  = 21'd1048576;
  localparam logic [DATA_W-1:0] PRESS_SCALE = 64'd3125;
  localparam logic [DATA_W-1:0] PRESS_BIAS  = 64'h0000_8000_0000_0000;
  localparam logic signed [35:0] CENT_ROUND = 36'sd128;

endpackage

/* hw/rtl/ptc_mul.sv */
// ----------------------------------------------------------------------------
// ptc_mul
// Bit-serial shift-and-add multiplier giving the low DATA_W bits of a signed
// product. One multiplier bit is consumed per cycle; the run ends as soon as
// the remaining magnitude bits are zero.
// ----------------------------------------------------------------------------
module ptc_mul import ptc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] mcand,
  input  logic [DATA_W-1:0] mplier,
  output logic              done,
  output logic [DATA_W-1:0] product
);

  logic              run_r;
  logic              done_r;
  logic              neg_r;
  logic [DATA_W-1:0] mcand_r;
  logic [DATA_W-1:0] mag_r;
  logic [DATA_W-1:0] acc_r;
  logic [DATA_W-1:0] product_r;
  logic              last;

  // The run finishes once no magnitude bits are left.
  assign last = run_r && (mag_r == '0);

  // Control: busy flag and a one-cycle done pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= last;
      if (start) begin
        run_r <= 1'b1;
      end else if (last) begin
        run_r <= 1'b0;
      end
    end
  end

  // Datapath: the multiplier is taken as sign and magnitude, the product is
  // negated at the end, which is exact modulo 2^DATA_W.
  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r <= mcand;
      mag_r   <= mplier[DATA_W-1] ? (~mplier + 1'b1) : mplier;
      neg_r   <= mplier[DATA_W-1];
      acc_r   <= '0;
    end else if (last) begin
      product_r <= neg_r ? (~acc_r + 1'b1) : acc_r;
    end else if (run_r) begin
      if (mag_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r <= mcand_r << 1;
      mag_r   <= mag_r >> 1;
    end
  end

  assign done    = done_r;
  assign product = product_r;

endmodule

/* hw/rtl/ptc_div.sv */
// ----------------------------------------------------------------------------
// ptc_div
// Restoring signed divider, one quotient bit per cycle. The quotient
// truncates toward zero and wraps to DATA_W bits. The divisor must not be
// zero.
// ----------------------------------------------------------------------------
module ptc_div import ptc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              done,
  output logic [DATA_W-1:0] quotient
);

  logic              run_r;
  logic              done_r;
  logic              neg_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DATA_W-1:0] quo_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] dvs_r;
  logic [DATA_W-1:0] quotient_r;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   diff;
  logic              last;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign rem_sh = {rem_r, quo_r[DATA_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};
  assign last   = run_r && (cnt_r == CNT_W'(DATA_W));

  // Control: busy flag and a one-cycle done pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= last;
      if (start) begin
        run_r <= 1'b1;
      end else if (last) begin
        run_r <= 1'b0;
      end
    end
  end

  // Datapath: magnitudes in, sign applied to the quotient at the end.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
      dvs_r <= divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
      neg_r <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
      rem_r <= '0;
      cnt_r <= '0;
    end else if (last) begin
      quotient_r <= neg_r ? (~quo_r + 1'b1) : quo_r;
    end else if (run_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (!diff[DATA_W]) begin
        rem_r <= diff[DATA_W-1:0];
        quo_r <= {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[DATA_W-1:0];
        quo_r <= {quo_r[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = quotient_r;

endmodule

/* hw/rtl/pressure_temperature_compensation.sv */
// ----------------------------------------------------------------------------
// pressure_temperature_compensation
// Thirteen products run on the shared bit-serial multiplier and the pressure
// quotient on the serial divider; a pair of skipped conversions uses neither.
// One item is processed at a time; an input transfer is taken while a result
// waits in the output register. Reset clears calibration and fine temperature.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation import ptc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  // Configuration write port.
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [DATA_W-1:0]       cfg_wdata,
  // Raw conversion input.
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [RAW_W-1:0]        in_raw_temperature,
  input  logic [RAW_W-1:0]        in_raw_pressure,
  // Compensated result output.
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] out_temperature_centi,
  output logic                    out_temperature_valid,
  output logic [OUT_W-1:0]        out_pressure_q24_8,
  output logic                    out_pressure_valid
);

  // Sequencer states.
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_T_M1   = 5'd1;
  localparam logic [4:0] S_T_M2   = 5'd2;
  localparam logic [4:0] S_T_M3   = 5'd3;
  localparam logic [4:0] S_T_CENT = 5'd4;
  localparam logic [4:0] S_P_INIT = 5'd5;
  localparam logic [4:0] S_P_M1   = 5'd6;
  localparam logic [4:0] S_P_M2   = 5'd7;
  localparam logic [4:0] S_P_M3   = 5'd8;
  localparam logic [4:0] S_P_M4   = 5'd9;
  localparam logic [4:0] S_P_M5   = 5'd10;
  localparam logic [4:0] S_P_M6   = 5'd11;
  localparam logic [4:0] S_P_CHK  = 5'd12;
  localparam logic [4:0] S_P_M7   = 5'd13;
  localparam logic [4:0] S_P_DIV  = 5'd14;
  localparam logic [4:0] S_P_M8   = 5'd15;
  localparam logic [4:0] S_P_M9   = 5'd16;
  localparam logic [4:0] S_P_M10  = 5'd17;
  localparam logic [4:0] S_P_FIN  = 5'd18;
  localparam logic [4:0] S_OUT    = 5'd19;

  function automatic logic [DATA_W-1:0] sra(input logic [DATA_W-1:0] v,
                                            input logic [5:0] s);
    sra = $unsigned($signed(v) >>> s);
  endfunction

  function automatic logic [DATA_W-1:0] sx16(input logic [15:0] v);
    sx16 = {{(DATA_W-16){v[15]}}, v};
  endfunction

  // Control registers.
  logic [4:0]               state_r;
  logic [4:0]               state_nxt;
  logic                     mul_wait_r;
  logic                     div_wait_r;
  logic                     out_valid_r;
  logic [FINE_W-1:0]        fine_r;

  // Calibration registers.
  logic [47:0]              cal_t_r;
  logic [DATA_W-1:0]        cal_pl_r;
  logic [DATA_W-1:0]        cal_ph_r;
  logic [15:0]              cal_p9_r;

  // Working registers.
  logic [RAW_W-1:0]         raw_t_r;
  logic [RAW_W-1:0]         raw_p_r;
  logic [DATA_W-1:0]        acc_r;
  logic [DATA_W-1:0]        s1_r;
  logic [DATA_W-1:0]        v1_r;
  logic [DATA_W-1:0]        v2_r;
  logic [DATA_W-1:0]        x_r;
  logic [DATA_W-1:0]        dv_r;
  logic [DATA_W-1:0]        p_r;
  logic signed [OUT_W-1:0]  tcent_r;
  logic                     tvalid_r;
  logic [OUT_W-1:0]         pout_r;
  logic                     pvalid_r;

  // Output register.
  logic signed [OUT_W-1:0]  out_tc_r;
  logic                     out_tv_r;
  logic [OUT_W-1:0]         out_pq_r;
  logic                     out_pv_r;

  // Shared units.
  logic                     mul_req;
  logic                     mul_start;
  logic [DATA_W-1:0]        mul_a;
  logic [DATA_W-1:0]        mul_b;
  logic                     mul_done;
  logic [DATA_W-1:0]        mul_prod;
  logic                     div_start;
  logic                     div_done;
  logic [DATA_W-1:0]        div_quo;

  // Combinational helpers.
  logic                     in_fire;
  logic                     out_load;
  logic signed [17:0]       d1;
  logic signed [16:0]       d2;
  logic [DATA_W-1:0]        fine_b;
  logic [FINE_W-1:0]        fine_sum;
  logic signed [35:0]       fine36;
  logic signed [35:0]       cent36;
  logic [RAW_W:0]           pdiff;
  logic [DATA_W-1:0]        qsh;
  logic [39:0]              psum40;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_ready);
  assign mul_start = mul_req && !mul_wait_r;
  assign div_start = (state_r == S_P_DIV) && !div_wait_r;

  // Temperature differences from the raw value and T1.
  assign d1 = $signed({1'b0, raw_t_r[RAW_W-1:3]}) - $signed({1'b0, cal_t_r[47:32], 1'b0});
  assign d2 = $signed({1'b0, raw_t_r[RAW_W-1:4]}) - $signed({1'b0, cal_t_r[47:32]});

  // Fine temperature keeps only its low 32 bits.
  assign fine_b   = sra(mul_prod, 6'd14);
  assign fine_sum = acc_r[FINE_W-1:0] + fine_b[FINE_W-1:0];

  // Hundredths of a degree: (fine * 5 + 128) >> 8.
  assign fine36 = {{4{fine_r[FINE_W-1]}}, fine_r};
  assign cent36 = (fine36 <<< 2) + fine36 + CENT_ROUND;

  // Pressure offset term, the shifted pressure that is squared, and the final sum.
  assign pdiff  = PRESS_BASE - {1'b0, raw_p_r};
  assign qsh    = sra(p_r, 6'd13);
  assign psum40 = acc_r[39:0] + p_r[39:0];

  // Multiplier operand selection per step.
  always_comb begin
    mul_req = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    case (state_r)
      S_T_M1: begin
        mul_req = 1'b1;
        mul_a   = {{(DATA_W-18){d1[17]}}, d1};
        mul_b   = sx16(cal_t_r[31:16]);
      end
      S_T_M2: begin
        mul_req = 1'b1;
        mul_a   = {{(DATA_W-17){d2[16]}}, d2};
        mul_b   = {{(DATA_W-17){d2[16]}}, d2};
      end
      S_T_M3: begin
        mul_req = 1'b1;
        mul_a   = s1_r;
        mul_b   = sx16(cal_t_r[15:0]);
      end
      S_P_M1: begin
        mul_req = 1'b1;
        mul_a   = v1_r;
        mul_b   = v1_r;
      end
      S_P_M2: begin
        mul_req = 1'b1;
        mul_a   = s1_r;
        mul_b   = sx16(cal_ph_r[47:32]);
      end
      S_P_M3: begin
        mul_req = 1'b1;
        mul_a   = v1_r;
        mul_b   = sx16(cal_ph_r[63:48]);
      end
      S_P_M4: begin
        mul_req = 1'b1;
        mul_a   = s1_r;
        mul_b   = sx16(cal_pl_r[31:16]);
      end
      S_P_M5: begin
        mul_req = 1'b1;
        mul_a   = v1_r;
        mul_b   = sx16(cal_pl_r[47:32]);
      end
      S_P_M6: begin
        mul_req = 1'b1;
        mul_a   = x_r + PRESS_BIAS;
        mul_b   = {{(DATA_W-16){1'b0}}, cal_pl_r[63:48]};
      end
      S_P_M7: begin
        mul_req = 1'b1;
        mul_a   = ({{(DATA_W-RAW_W-1){1'b0}}, pdiff} << 31) - v2_r;
        mul_b   = PRESS_SCALE;
      end
      S_P_M8: begin
        mul_req = 1'b1;
        mul_a   = qsh;
        mul_b   = qsh;
      end
      S_P_M9: begin
        mul_req = 1'b1;
        mul_a   = s1_r;
        mul_b   = sx16(cal_p9_r);
      end
      S_P_M10: begin
        mul_req = 1'b1;
        mul_a   = p_r;
        mul_b   = sx16(cal_ph_r[15:0]);
      end
      default: begin
        mul_req = 1'b0;
      end
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_raw_temperature == SKIP_MARK) ? S_P_INIT : S_T_M1;
        end
      end
      S_T_M1:   if (mul_done) state_nxt = S_T_M2;
      S_T_M2:   if (mul_done) state_nxt = S_T_M3;
      S_T_M3:   if (mul_done) state_nxt = S_T_CENT;
      S_T_CENT: state_nxt = S_P_INIT;
      S_P_INIT: state_nxt = (raw_p_r == SKIP_MARK) ? S_OUT : S_P_M1;
      S_P_M1:   if (mul_done) state_nxt = S_P_M2;
      S_P_M2:   if (mul_done) state_nxt = S_P_M3;
      S_P_M3:   if (mul_done) state_nxt = S_P_M4;
      S_P_M4:   if (mul_done) state_nxt = S_P_M5;
      S_P_M5:   if (mul_done) state_nxt = S_P_M6;
      S_P_M6:   if (mul_done) state_nxt = S_P_CHK;
      S_P_CHK:  state_nxt = (dv_r == '0) ? S_OUT : S_P_M7;
      S_P_M7:   if (mul_done) state_nxt = S_P_DIV;
      S_P_DIV:  if (div_done) state_nxt = S_P_M8;
      S_P_M8:   if (mul_done) state_nxt = S_P_M9;
      S_P_M9:   if (mul_done) state_nxt = S_P_M10;
      S_P_M10:  if (mul_done) state_nxt = S_P_FIN;
      S_P_FIN:  state_nxt = S_OUT;
      S_OUT:    if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Control state, unit handshakes, stored fine temperature and calibration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mul_wait_r  <= 1'b0;
      div_wait_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fine_r      <= '0;
      cal_t_r     <= '0;
      cal_pl_r    <= '0;
      cal_ph_r    <= '0;
      cal_p9_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (mul_start) begin
        mul_wait_r <= 1'b1;
      end else if (mul_done) begin
        mul_wait_r <= 1'b0;
      end
      if (div_start) begin
        div_wait_r <= 1'b1;
      end else if (div_done) begin
        div_wait_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if ((state_r == S_T_M3) && mul_done) begin
        fine_r <= fine_sum;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_TEMP_CAL:   cal_t_r  <= cfg_wdata[47:0];
          REG_PRESS_LOW:  cal_pl_r <= cfg_wdata;
          REG_PRESS_HIGH: cal_ph_r <= cfg_wdata;
          REG_PRESS_NINE: cal_p9_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end
    end
  end

  // Working datapath: each step stores its product with its shift and add.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          raw_t_r  <= in_raw_temperature;
          raw_p_r  <= in_raw_pressure;
          tcent_r  <= '0;
          tvalid_r <= 1'b0;
          pout_r   <= '0;
          pvalid_r <= 1'b0;
        end
      end
      S_T_M1:   if (mul_done) acc_r <= sra(mul_prod, 6'd11);
      S_T_M2:   if (mul_done) s1_r <= sra(mul_prod, 6'd12);
      S_T_M3:   if (mul_done) tvalid_r <= 1'b1;
      S_T_CENT: tcent_r <= {{4{cent36[35]}}, cent36[35:8]};
      S_P_INIT: v1_r <= {{(DATA_W-FINE_W){fine_r[FINE_W-1]}}, fine_r} - TEMP_OFFSET;
      S_P_M1:   if (mul_done) s1_r <= mul_prod;
      S_P_M2:   if (mul_done) v2_r <= mul_prod + (sx16(cal_pl_r[15:0]) << 35);
      S_P_M3:   if (mul_done) v2_r <= v2_r + (mul_prod << 17);
      S_P_M4:   if (mul_done) x_r <= sra(mul_prod, 6'd8);
      S_P_M5:   if (mul_done) x_r <= x_r + (mul_prod << 12);
      S_P_M6:   if (mul_done) dv_r <= sra(mul_prod, 6'd33);
      S_P_M7:   if (mul_done) x_r <= mul_prod;
      S_P_DIV:  if (div_done) p_r <= div_quo;
      S_P_M8:   if (mul_done) s1_r <= mul_prod;
      S_P_M9:   if (mul_done) acc_r <= sra(mul_prod, 6'd25);
      S_P_M10:  if (mul_done) acc_r <= acc_r + sra(mul_prod, 6'd19);
      S_P_FIN: begin
        pout_r   <= psum40[39:8] + {{12{cal_ph_r[31]}}, cal_ph_r[31:16], 4'b0000};
        pvalid_r <= 1'b1;
      end
      S_OUT: begin
        if (out_load) begin
          out_tc_r <= tcent_r;
          out_tv_r <= tvalid_r;
          out_pq_r <= pout_r;
          out_pv_r <= pvalid_r;
        end
      end
      default: ;
    endcase
  end

  // Shared bit-serial multiplier.
  ptc_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (mul_a),
    .mplier  (mul_b),
    .done    (mul_done),
    .product (mul_prod)
  );

  // Serial divider for the pressure quotient.
  ptc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (x_r),
    .divisor  (dv_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign out_valid             = out_valid_r;
  assign out_temperature_centi = out_tc_r;
  assign out_temperature_valid = out_tv_r;
  assign out_pressure_q24_8    = out_pq_r;
  assign out_pressure_valid    = out_pv_r;

endmodule

/* hw/rtl/ptc_checker.sv */
// ----------------------------------------------------------------------------
// ptc_checker
// Port-level checks of the compensation block, attached by a bind.
// ----------------------------------------------------------------------------
module ptc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_we,
  input logic [7:0]  cfg_index,
  input logic [63:0] cfg_wdata,
  input logic        in_valid,
  input logic        in_ready,
  input logic [19:0] in_raw_temperature,
  input logic [19:0] in_raw_pressure,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_temperature_centi,
  input logic        out_temperature_valid,
  input logic [31:0] out_pressure_q24_8,
  input logic        out_pressure_valid
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_temperature_centi) &&
      $stable(out_pressure_q24_8) && $stable(out_temperature_valid) &&
      $stable(out_pressure_valid))
    else $error("result payload changed while stalled");

  // The block works on one item at a time after an input transfer.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  // An invalid temperature reads as zero.
  a_temp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_temperature_valid |-> out_temperature_centi == 32'd0)
    else $error("invalid temperature is not zero");

  // An invalid pressure reads as zero.
  a_press_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pressure_valid |-> out_pressure_q24_8 == 32'd0)
    else $error("invalid pressure is not zero");

endmodule

bind pressure_temperature_compensation ptc_checker u_ptc_checker (.*);
